>>> src/ptd_pkg.sv
// Package for the periodic task dispatch table.
// Holds request, reply and status codes, the slot entry layout and the result word.
// No dependencies.
package ptd_pkg;

  localparam int unsigned DefNumSlots = 16;

  localparam logic [1:0] REQ_CREATE = 2'd0;
  localparam logic [1:0] REQ_DELETE = 2'd1;
  localparam logic [1:0] REQ_SCAN   = 2'd2;

  localparam logic [1:0] KIND_STATUS   = 2'd0;
  localparam logic [1:0] KIND_DISPATCH = 2'd1;
  localparam logic [1:0] KIND_DONE     = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_INV_ARG  = 3'd2;
  localparam logic [2:0] ST_NO_FREE  = 3'd3;
  localparam logic [2:0] ST_INV_SLOT = 3'd4;
  localparam logic [2:0] ST_SKIPPED  = 3'd5;

  typedef struct packed {
    logic [15:0] handle;
    logic [31:0] period;
    logic [31:0] ran_ms;
    logic [31:0] runs;
  } slot_entry_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  status;
    logic [3:0]  slot;
    logic [15:0] handle;
    logic [31:0] count;
    logic        last;
  } result_t;

endpackage

>>> src/ptd_slot_mem.sv
// Slot table memory: one write port, one read port, registered read data.
// Depends on ptd_pkg for the entry layout.
module ptd_slot_mem #(
  parameter int unsigned NUM_SLOTS = ptd_pkg::DefNumSlots,
  localparam int unsigned IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [IdxW-1:0]       waddr_i,
  input  ptd_pkg::slot_entry_t  wdata_i,
  input  logic                  re_i,
  input  logic [IdxW-1:0]       raddr_i,
  output ptd_pkg::slot_entry_t  rdata_o
);
  import ptd_pkg::*;

  slot_entry_t mem_q [NUM_SLOTS];
  slot_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/ptd_out_stage.sv
// Output register between the sequencer and the result stream.
// Depends on ptd_pkg for the result word.
module ptd_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  ptd_pkg::result_t  res_i,
  output logic              free_o,
  output logic              valid_o,
  input  logic              ready_i,
  output ptd_pkg::result_t  res_o
);
  import ptd_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_i) begin
      valid_d = 1'b0;
    end
    if (load_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

>>> src/ptd_ctrl.sv
// Request sequencer: valid bits, counters, create/delete handling and the slot scan.
// Depends on ptd_pkg; drives ptd_slot_mem and ptd_out_stage.
module ptd_ctrl #(
  parameter int unsigned NUM_SLOTS = ptd_pkg::DefNumSlots,
  localparam int unsigned IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1,
  localparam int unsigned CntW = $clog2(NUM_SLOTS + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            in_req_type_i,
  input  logic [31:0]           in_now_i,
  input  logic [15:0]           in_handle_i,
  input  logic [31:0]           in_period_i,
  input  logic [7:0]            in_target_i,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [15:0]           cfg_data_i,
  input  logic                  out_free_i,
  output logic                  res_load_o,
  output ptd_pkg::result_t      res_o,
  output logic                  mem_we_o,
  output logic [IdxW-1:0]       mem_waddr_o,
  output ptd_pkg::slot_entry_t  mem_wdata_o,
  output logic                  mem_re_o,
  output logic [IdxW-1:0]       mem_raddr_o,
  input  ptd_pkg::slot_entry_t  mem_rdata_i
);
  import ptd_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CMD  = 5'b00010,
    S_SCHK = 5'b00100,
    S_SCAN = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  localparam logic [CntW-1:0] NumSlotsC = CntW'(NUM_SLOTS);
  localparam logic [CntW-1:0] OneC      = CntW'(1);
  localparam logic [7:0]      NumSlotsB = 8'(NUM_SLOTS);

  state_e               state_q, state_d;
  logic [NUM_SLOTS-1:0] valid_q, valid_d;
  logic [CntW-1:0]      used_q, used_d;
  logic [31:0]          last_scan_q, last_scan_d;
  logic [15:0]          min_q, min_d;
  logic [CntW-1:0]      rd_idx_q, rd_idx_d;
  logic                 ev_q, ev_d;
  logic [IdxW-1:0]      ev_idx_q, ev_idx_d;

  logic [1:0]  req_q;
  logic [31:0] now_q;
  logic [15:0] handle_q;
  logic [31:0] period_q;
  logic [7:0]  target_q;

  logic [IdxW-1:0] free_idx;
  logic            free_found;
  logic [IdxW-1:0] tgt_idx;
  logic            tgt_ok;
  logic [31:0]     scan_gap;
  logic [31:0]     slot_gap;
  logic [31:0]     next_count;
  logic            hit;

  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx   = IdxW'(i);
        free_found = 1'b1;
      end
    end
  end

  assign tgt_idx    = target_q[IdxW-1:0];
  assign tgt_ok     = (target_q < NumSlotsB) && valid_q[tgt_idx];
  assign scan_gap   = now_q - last_scan_q;
  assign slot_gap   = now_q - mem_rdata_i.ran_ms;
  assign next_count = mem_rdata_i.runs + 32'd1;
  assign hit        = ev_q && valid_q[ev_idx_q] && (slot_gap >= mem_rdata_i.period);

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign mem_raddr_o = rd_idx_q[IdxW-1:0];

  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    used_d      = used_q;
    last_scan_d = last_scan_q;
    rd_idx_d    = rd_idx_q;
    ev_d        = ev_q;
    ev_idx_d    = ev_idx_q;
    min_d       = min_q;
    res_load_o  = 1'b0;
    res_o       = '0;
    res_o.last  = 1'b1;
    mem_we_o    = 1'b0;
    mem_waddr_o = ev_idx_q;
    mem_wdata_o = '{handle: mem_rdata_i.handle, period: mem_rdata_i.period,
                    ran_ms: now_q, runs: next_count};
    mem_re_o    = 1'b0;

    if (cfg_valid_i) begin
      min_d = cfg_data_i;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = (in_req_type_i == REQ_SCAN) ? S_SCHK : S_CMD;
        end
      end
      S_CMD: begin
        if (out_free_i) begin
          res_load_o = 1'b1;
          res_o.kind = KIND_STATUS;
          state_d    = S_IDLE;
          case (req_q)
            REQ_CREATE: begin
              if (used_q >= NumSlotsC) begin
                res_o.status = ST_FULL;
              end else if (handle_q == '0 || period_q == '0) begin
                res_o.status = ST_INV_ARG;
              end else if (!free_found) begin
                res_o.status = ST_NO_FREE;
              end else begin
                res_o.status      = ST_OK;
                res_o.slot        = 4'(free_idx);
                valid_d[free_idx] = 1'b1;
                used_d            = used_q + OneC;
                mem_we_o          = 1'b1;
                mem_waddr_o       = free_idx;
                mem_wdata_o       = '{handle: handle_q, period: period_q,
                                      ran_ms: now_q, runs: 32'd0};
              end
            end
            REQ_DELETE: begin
              if (!tgt_ok) begin
                res_o.status = ST_INV_SLOT;
              end else begin
                res_o.status     = ST_OK;
                res_o.slot       = 4'(tgt_idx);
                valid_d[tgt_idx] = 1'b0;
                if (used_q != '0) begin
                  used_d = used_q - OneC;
                end
              end
            end
            default: begin
              res_o.status = ST_INV_ARG;
            end
          endcase
        end
      end
      S_SCHK: begin
        if (scan_gap < {16'd0, min_q}) begin
          if (out_free_i) begin
            res_load_o   = 1'b1;
            res_o.kind   = KIND_DONE;
            res_o.status = ST_SKIPPED;
            state_d      = S_IDLE;
          end
        end else begin
          last_scan_d = now_q;
          rd_idx_d    = '0;
          ev_d        = 1'b0;
          state_d     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!hit || out_free_i) begin
          if (hit) begin
            mem_we_o     = 1'b1;
            res_load_o   = 1'b1;
            res_o.kind   = KIND_DISPATCH;
            res_o.status = ST_OK;
            res_o.slot   = 4'(ev_idx_q);
            res_o.handle = mem_rdata_i.handle;
            res_o.count  = next_count;
            res_o.last   = 1'b0;
          end
          if (rd_idx_q != NumSlotsC) begin
            mem_re_o = 1'b1;
            ev_d     = 1'b1;
            ev_idx_d = rd_idx_q[IdxW-1:0];
            rd_idx_d = rd_idx_q + OneC;
          end else begin
            ev_d    = 1'b0;
            state_d = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (out_free_i) begin
          res_load_o   = 1'b1;
          res_o.kind   = KIND_DONE;
          res_o.status = ST_OK;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      used_q      <= '0;
      last_scan_q <= '0;
      min_q       <= 16'd1;
      rd_idx_q    <= '0;
      ev_q        <= 1'b0;
      ev_idx_q    <= '0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      used_q      <= used_d;
      last_scan_q <= last_scan_d;
      min_q       <= min_d;
      rd_idx_q    <= rd_idx_d;
      ev_q        <= ev_d;
      ev_idx_q    <= ev_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q    <= in_req_type_i;
      now_q    <= in_now_i;
      handle_q <= in_handle_i;
      period_q <= in_period_i;
      target_q <= in_target_i;
    end
  end

endmodule

>>> src/periodic_task_dispatch_table_core.sv
// Top level of the periodic task dispatch table.
// Depends on ptd_pkg, ptd_slot_mem, ptd_out_stage and ptd_ctrl.
//
//  channel  dir  tdata (low bit up)                          tuser      tlast
//  s_axis   in   now_ms 32, task_handle 16, task_period 32,  req_type   -
//                target_slot 8
//  m_axis   out  status_code 3, slot_index 4,                reply_kind last_of_run
//                dispatched_handle 16, run_count 32, pad 1
//  cfg      in   min_scan_interval 16 (cfg_data_i)           -          -
//
// Create and delete are decided in the command state and registered in the output
// stage. A run scan does one read-modify-write of the slot memory per slot, read of
// slot i+1 overlapped with write-back of slot i. Reset clears all valid bits
// at once: no clearing pass. A stalled result stream holds the scan at a due slot.
module periodic_task_dispatch_table_core #(
  parameter int unsigned NUM_SLOTS = ptd_pkg::DefNumSlots
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,   // now_ms, task_handle, task_period, target_slot
  input  logic [1:0]  s_axis_tuser,   // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // status_code, slot_index, dispatched_handle,
                                      // run_count, pad
  output logic [1:0]  m_axis_tuser,   // reply_kind
  output logic        m_axis_tlast,   // last_of_run
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);
  import ptd_pkg::*;

  localparam int unsigned IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  logic            out_free;
  logic            res_load;
  result_t         res_in;
  result_t         res_out;
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  slot_entry_t     mem_wdata;
  logic            mem_re;
  logic [IdxW-1:0] mem_raddr;
  slot_entry_t     mem_rdata;

  ptd_ctrl #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_req_type_i(s_axis_tuser),
    .in_now_i     (s_axis_tdata[31:0]),
    .in_handle_i  (s_axis_tdata[47:32]),
    .in_period_i  (s_axis_tdata[79:48]),
    .in_target_i  (s_axis_tdata[87:80]),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .out_free_i   (out_free),
    .res_load_o   (res_load),
    .res_o        (res_in),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  ptd_slot_mem #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  ptd_out_stage u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (res_load),
    .res_i  (res_in),
    .free_o (out_free),
    .valid_o(m_axis_tvalid),
    .ready_i(m_axis_tready),
    .res_o  (res_out)
  );

  assign m_axis_tdata = {1'b0, res_out.count, res_out.handle, res_out.slot, res_out.status};
  assign m_axis_tuser = res_out.kind;
  assign m_axis_tlast = res_out.last;

endmodule
